// ===== design/ttb_pkg.sv =====
package ttb_pkg;

    // Normalized magnitudes keep their top set bit here
    localparam int NORM_TOP  = 29;
    localparam int M_BITS    = NORM_TOP + 1;
    localparam int SQ_BITS   = 2 * M_BITS + 2;
    localparam int LEN_BITS  = M_BITS + 1;
    localparam int REM_BITS  = LEN_BITS + 1;
    localparam int N_STEPS   = 14;

    typedef logic [M_BITS-1:0]  mant_t;
    typedef logic [SQ_BITS-1:0] sq_t;

endpackage

// ===== design/triangle_tangent_bitangent.sv =====
// A first or second vertex of a face is taken and gives no word.
// The third vertex starts the computation, which gives its word at the end of these steps:
// shared multiply and subtract, one determinant check, then per vector magnitude, align and
// square, 31 root steps and three divides. No vertex is taken until the word is loaded out;
// a zero determinant gives its word without the vector steps.
// A word not yet taken holds the block at completion. Reset clears phase and control.
module triangle_tangent_bitangent #(
    parameter int COORD_WIDTH   = 32,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v (lowest bits first), zero padded
    input  logic [((5*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z, zero padded
    output logic [((6*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
    // degenerate
    output logic m_tuser
);
    import ttb_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;
    localparam int MW   = (DW > M_BITS + 1) ? DW : M_BITS + 1;
    localparam int AW   = 2 * MW + 1;
    localparam int OW   = OUT_FRAC_BITS + 2;
    localparam int QB   = OUT_FRAC_BITS + 1;
    localparam int DVW  = M_BITS + OUT_FRAC_BITS + 1;
    localparam int OWB  = ((6 * OW + 7) / 8) * 8;
    localparam int ITW  = $clog2(QB);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_CHK, S_MAG, S_NORM, S_SQ, S_SQA,
        S_SQRT, S_DIVI, S_DIV, S_DIVW, S_DONE
    } state_t;

    state_t          state_reg;
    logic [1:0]      phase_reg;
    logic [3:0]      step_reg;
    logic [1:0]      comp_reg;
    logic            vec_reg;
    logic [ITW-1:0]  iter_reg;
    logic            m_tvalid_reg;
    logic            degen_reg;

    logic signed [CW-1:0]   st_reg [10];
    logic signed [DW-1:0]   e1_reg [3];
    logic signed [DW-1:0]   e2_reg [3];
    logic signed [DW-1:0]   du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [2*MW-1:0] prod_reg;
    logic signed [AW-1:0]   acc_reg;
    logic signed [AW-1:0]   slot_reg [7];
    logic                   flip_reg;
    logic [AW-1:0]          mag_reg [3];
    logic [AW-1:0]          orw_reg;
    logic                   neg_reg [3];
    sq_t                    sum_reg, x_reg, res_reg, bit_reg;
    logic [REM_BITS-1:0]    rem_reg;
    logic [QB-1:0]          dlow_reg, q_reg;
    logic [OW-1:0]          vout_reg [6];
    logic [OW-1:0]          out_reg [6];
    logic                   out_deg_reg;

    logic            in_acc;
    logic [2:0]      pair;
    logic signed [MW-1:0] mul_a, mul_b;
    logic [2:0]      sidx;
    logic signed [AW-1:0] src;
    logic            norm_done;
    sq_t             rb;
    logic [LEN_BITS-1:0] len;
    logic [DVW-1:0]  dvd;
    logic [REM_BITS:0] r2;
    logic [QB-1:0]   qc;
    logic [OW-1:0]   qs;
    logic            load_out;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign pair     = step_reg[3:1];
    assign load_out = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_SQ)
        begin
            mul_a = MW'(signed'({1'b0, mag_reg[comp_reg][M_BITS-1:0]}));
            mul_b = mul_a;
        end
        else
        begin
            case (pair)
                3'd0:
                begin
                    mul_a = step_reg[0] ? MW'(du2_reg) : MW'(du1_reg);
                    mul_b = step_reg[0] ? MW'(dv1_reg) : MW'(dv2_reg);
                end
                3'd1, 3'd2, 3'd3:
                begin
                    mul_a = step_reg[0] ? MW'(dv1_reg) : MW'(dv2_reg);
                    mul_b = step_reg[0] ? MW'(e2_reg[2'(pair - 3'd1)])
                                        : MW'(e1_reg[2'(pair - 3'd1)]);
                end
                default:
                begin
                    mul_a = step_reg[0] ? MW'(du2_reg) : MW'(du1_reg);
                    mul_b = step_reg[0] ? MW'(e1_reg[2'(pair - 3'd4)])
                                        : MW'(e2_reg[2'(pair - 3'd4)]);
                end
            endcase
        end
    end

    assign sidx      = vec_reg ? 3'd4 + 3'(comp_reg) : 3'd1 + 3'(comp_reg);
    assign src       = slot_reg[sidx];
    assign norm_done = orw_reg[NORM_TOP] && !(|orw_reg[AW-1:NORM_TOP+1]);
    assign rb        = res_reg + bit_reg;
    assign len       = res_reg[LEN_BITS-1:0];
    assign dvd       = DVW'({mag_reg[comp_reg][M_BITS-1:0], {OUT_FRAC_BITS{1'b0}}})
                     + DVW'(len >> 1);
    assign r2        = {rem_reg, dlow_reg[QB-1]};
    assign qc        = (q_reg > (QB'(1) << OUT_FRAC_BITS)) ? (QB'(1) << OUT_FRAC_BITS) : q_reg;
    assign qs        = neg_reg[comp_reg] ? OW'(-OW'(qc)) : OW'(qc);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= 2'd0;
            step_reg     <= '0;
            comp_reg     <= '0;
            vec_reg      <= 1'b0;
            iter_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            degen_reg    <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && !load_out)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (phase_reg == 2'd2)
                        begin
                            phase_reg <= 2'd0;
                            step_reg  <= '0;
                            degen_reg <= 1'b0;
                            state_reg <= S_MUL;
                        end
                        else
                            phase_reg <= phase_reg + 2'd1;
                    end
                end
                S_MUL: state_reg <= S_ACC;
                S_ACC:
                begin
                    if (step_reg == 4'(N_STEPS - 1))
                        state_reg <= S_CHK;
                    else
                    begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_CHK:
                begin
                    comp_reg <= '0;
                    vec_reg  <= 1'b0;
                    if (slot_reg[0] == '0)
                    begin
                        degen_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_MAG;
                end
                S_MAG:
                begin
                    if (comp_reg == 2'd2)
                    begin
                        comp_reg  <= '0;
                        state_reg <= S_NORM;
                    end
                    else
                        comp_reg <= comp_reg + 2'd1;
                end
                S_NORM:
                begin
                    if (orw_reg == '0)
                    begin
                        degen_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (norm_done)
                        state_reg <= S_SQ;
                end
                S_SQ: state_reg <= S_SQA;
                S_SQA:
                begin
                    if (comp_reg == 2'd2)
                    begin
                        comp_reg  <= '0;
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= S_SQ;
                    end
                end
                S_SQRT:
                begin
                    if (bit_reg == sq_t'(1))
                        state_reg <= S_DIVI;
                end
                S_DIVI:
                begin
                    iter_reg  <= ITW'(QB - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (iter_reg == '0)
                        state_reg <= S_DIVW;
                    else
                        iter_reg <= iter_reg - ITW'(1);
                end
                S_DIVW:
                begin
                    if (comp_reg == 2'd2)
                    begin
                        comp_reg <= '0;
                        if (vec_reg)
                            state_reg <= S_DONE;
                        else
                        begin
                            vec_reg   <= 1'b1;
                            state_reg <= S_MAG;
                        end
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= S_DIVI;
                    end
                end
                S_DONE:
                begin
                    if (load_out)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (phase_reg == 2'd2)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            e1_reg[i] <= DW'(st_reg[5+i]) - DW'(st_reg[i]);
                            e2_reg[i] <= DW'(signed'(s_tdata[i*CW +: CW])) - DW'(st_reg[i]);
                        end
                        du1_reg <= DW'(st_reg[8]) - DW'(st_reg[3]);
                        dv1_reg <= DW'(st_reg[9]) - DW'(st_reg[4]);
                        du2_reg <= DW'(signed'(s_tdata[3*CW +: CW])) - DW'(st_reg[3]);
                        dv2_reg <= DW'(signed'(s_tdata[4*CW +: CW])) - DW'(st_reg[4]);
                    end
                    else
                    begin
                        for (int i = 0; i < 5; i++)
                        begin
                            if (phase_reg == 2'd0)
                                st_reg[i] <= s_tdata[i*CW +: CW];
                            else
                                st_reg[5+i] <= s_tdata[i*CW +: CW];
                        end
                    end
                end
            end
            S_MUL, S_SQ: prod_reg <= mul_a * mul_b;
            S_ACC:
            begin
                if (!step_reg[0])
                    acc_reg <= AW'(prod_reg);
                else
                    slot_reg[pair] <= acc_reg - AW'(prod_reg);
            end
            S_CHK: flip_reg <= slot_reg[0][AW-1];
            S_MAG:
            begin
                mag_reg[comp_reg] <= src[AW-1] ? AW'(-src) : AW'(src);
                neg_reg[comp_reg] <= src[AW-1] ^ flip_reg;
                orw_reg <= ((comp_reg == 2'd0) ? AW'(0) : orw_reg)
                         | (src[AW-1] ? AW'(-src) : AW'(src));
            end
            S_NORM:
            begin
                // align so the largest magnitude has its top bit at NORM_TOP
                sum_reg <= '0;
                if (|orw_reg[AW-1:NORM_TOP+9])
                begin
                    orw_reg <= orw_reg >> 8;
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 8;
                end
                else if (|orw_reg[AW-1:NORM_TOP+1])
                begin
                    orw_reg <= orw_reg >> 1;
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                end
                else if (orw_reg[AW-1:NORM_TOP-7] == '0)
                begin
                    orw_reg <= orw_reg << 8;
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 8;
                end
                else if (!orw_reg[NORM_TOP])
                begin
                    orw_reg <= orw_reg << 1;
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                end
            end
            S_SQA:
            begin
                sum_reg <= sum_reg + sq_t'(prod_reg[SQ_BITS-3:0]);
                x_reg   <= sum_reg + sq_t'(prod_reg[SQ_BITS-3:0]);
                res_reg <= '0;
                bit_reg <= sq_t'(1) << (SQ_BITS - 2);
            end
            S_SQRT:
            begin
                if (x_reg >= rb)
                begin
                    x_reg   <= x_reg - rb;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            S_DIVI:
            begin
                rem_reg  <= REM_BITS'(dvd >> QB);
                dlow_reg <= dvd[QB-1:0];
                q_reg    <= '0;
            end
            S_DIV:
            begin
                if (r2 >= (REM_BITS + 1)'(len))
                begin
                    rem_reg <= REM_BITS'(r2 - (REM_BITS + 1)'(len));
                    q_reg   <= {q_reg[QB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= r2[REM_BITS-1:0];
                    q_reg   <= {q_reg[QB-2:0], 1'b0};
                end
                dlow_reg <= dlow_reg << 1;
            end
            S_DIVW: vout_reg[(vec_reg ? 3'd3 : 3'd0) + 3'(comp_reg)] <= qs;
            S_DONE:
            begin
                if (load_out)
                begin
                    for (int i = 0; i < 6; i++)
                        out_reg[i] <= degen_reg ? '0 : vout_reg[i];
                    out_deg_reg <= degen_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_deg_reg;
    assign m_tdata  = OWB'({out_reg[5], out_reg[4], out_reg[3],
                            out_reg[2], out_reg[1], out_reg[0]});

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("degenerate word carries non-zero vectors");

    a_early_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && phase_reg != 2'd2 |=> state_reg == S_IDLE)
        else $error("first or second vertex started a computation");

    a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("word raised outside completion");

endmodule

// ===== dv/triangle_tangent_bitangent_tb.sv =====
`timescale 1ns / 1ps

module triangle_tangent_bitangent_tb;

    localparam int CW        = 32;
    localparam int OFB       = 14;
    localparam int OW        = OFB + 2;
    localparam int IN_BITS   = ((5*CW+7)/8)*8;
    localparam int OUT_BITS  = ((6*OW+7)/8)*8;
    localparam int NORM_TOP  = 29;
    localparam int N_RANDOM  = 1900;
    localparam int SETTLE    = 400;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t tex_v;
        coord_t tex_u;
        coord_t pos_z;
        coord_t pos_y;
        coord_t pos_x;
    } vertex_t;

    typedef struct {
        logic [OW-1:0] comp [6];
        logic          degenerate;
    } frame_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_BITS-1:0] m_tdata;
    logic                m_tuser;

    triangle_tangent_bitangent #(.COORD_WIDTH(CW), .OUT_FRAC_BITS(OFB)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    class face_scoreboard;
        vertex_t corner [2];
        int      phase;
        frame_t  pending [$];
        int      mismatches;
        int      frames_seen;
        int      degenerate_seen;

        function new();
            phase = 0;
            mismatches = 0;
            frames_seen = 0;
            degenerate_seen = 0;
        endfunction

        // normalise one exact vector; returns 0 when all components are zero
        function automatic bit unit_vector(input logic signed [127:0] c [3], input bit flip,
                                           output logic [OW-1:0] o [3]);
            logic [127:0] mag [3];
            logic [63:0]  m [3];
            logic [63:0]  sum, len, rem, res, bit_w, q;
            bit           neg [3];
            int           top, bl;
            top = 0;
            for (int i = 0; i < 3; i++)
            begin
                neg[i] = c[i][127];
                mag[i] = neg[i] ? -c[i] : c[i];
                neg[i] ^= flip;
                bl = 0;
                for (int k = 0; k < 128; k++)
                    if (mag[i][k]) bl = k + 1;
                if (bl > top) top = bl;
            end
            if (top == 0) return 0;
            sum = 0;
            for (int i = 0; i < 3; i++)
            begin
                if (top - 1 >= NORM_TOP) m[i] = 64'(mag[i] >> (top - 1 - NORM_TOP));
                else m[i] = 64'(mag[i]) << (NORM_TOP - (top - 1));
                sum += m[i] * m[i];
            end
            rem = sum;
            res = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > rem) bit_w >>= 2;
            while (bit_w != 0)
            begin
                if (rem >= res + bit_w)
                begin
                    rem -= res + bit_w;
                    res = (res >> 1) + bit_w;
                end
                else res >>= 1;
                bit_w >>= 2;
            end
            len = res;
            for (int i = 0; i < 3; i++)
            begin
                q = ((m[i] << OFB) + (len >> 1)) / len;
                if (q > (64'd1 << OFB)) q = 64'd1 << OFB;
                o[i] = neg[i] ? OW'(-q) : OW'(q);
            end
            return 1;
        endfunction

        function automatic void note_vertex(input vertex_t v);
            logic signed [63:0]  e1 [3], e2 [3], p0 [3], du1, dv1, du2, dv2;
            logic signed [127:0] det, tv [3], bv [3];
            logic [OW-1:0]       ot [3], ob [3];
            frame_t              f;
            bit                  ok;
            if (phase < 2)
            begin
                corner[phase] = v;
                phase++;
                return;
            end
            phase = 0;
            p0[0] = corner[0].pos_x; p0[1] = corner[0].pos_y; p0[2] = corner[0].pos_z;
            e1[0] = 64'(corner[1].pos_x) - p0[0];
            e1[1] = 64'(corner[1].pos_y) - p0[1];
            e1[2] = 64'(corner[1].pos_z) - p0[2];
            e2[0] = 64'(v.pos_x) - p0[0];
            e2[1] = 64'(v.pos_y) - p0[1];
            e2[2] = 64'(v.pos_z) - p0[2];
            du1 = 64'(corner[1].tex_u) - 64'(corner[0].tex_u);
            dv1 = 64'(corner[1].tex_v) - 64'(corner[0].tex_v);
            du2 = 64'(v.tex_u) - 64'(corner[0].tex_u);
            dv2 = 64'(v.tex_v) - 64'(corner[0].tex_v);
            det = 128'(du1) * 128'(dv2) - 128'(du2) * 128'(dv1);
            for (int i = 0; i < 3; i++)
            begin
                tv[i] = 128'(dv2) * 128'(e1[i]) - 128'(dv1) * 128'(e2[i]);
                bv[i] = 128'(du1) * 128'(e2[i]) - 128'(du2) * 128'(e1[i]);
            end
            ok = det != 0;
            if (ok) ok = unit_vector(tv, det[127], ot);
            if (ok) ok = unit_vector(bv, det[127], ob);
            for (int i = 0; i < 3; i++)
            begin
                f.comp[i]   = ok ? ot[i] : '0;
                f.comp[i+3] = ok ? ob[i] : '0;
            end
            f.degenerate = !ok;
            pending = {pending, f};
        endfunction

        function automatic void check_frame(input logic [OUT_BITS-1:0] data, input logic flag);
            frame_t f;
            bit     bad;
            frames_seen++;
            if (flag) degenerate_seen++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected word %h deg=%b", $realtime, data, flag);
                return;
            end
            f = pending.pop_front();
            bad = flag !== f.degenerate;
            for (int i = 0; i < 6; i++)
                if (data[i*OW +: OW] !== f.comp[i]) bad = 1;
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: mismatch on word %0d", $realtime, frames_seen);
                    for (int i = 0; i < 6; i++)
                        $display("  comp %0d expected %h got %h", i, f.comp[i],
                                 data[i*OW +: OW]);
                    $display("  degenerate expected %b got %b", f.degenerate, flag);
                end
            end
        endfunction
    endclass

    face_scoreboard board;
    int  hold_off_cycles;
    bit  stimulus_done;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #200_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic coord_t rand_coord(input int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 32'h3FFFF)) - coord_t'(32'h20000);
            2: return ($urandom_range(0, 1)) ? 32'h7FFFFFFF : 32'h80000000;
            default: return coord_t'($urandom_range(0, 7)) - 4;
        endcase
    endfunction

    // hold the word until taken; drop valid only across a gap
    task automatic send_vertex(input vertex_t v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_BITS'(v);
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_vertex(v);
    endtask

    task automatic send_face(input vertex_t a, input vertex_t b, input vertex_t c);
        send_vertex(a);
        send_vertex(b);
        send_vertex(c);
    endtask

    function automatic vertex_t make_vertex(input coord_t x, input coord_t y, input coord_t z,
                                            input coord_t u, input coord_t v);
        vertex_t r;
        r.pos_x = x; r.pos_y = y; r.pos_z = z; r.tex_u = u; r.tex_v = v;
        return r;
    endfunction

    function automatic vertex_t rand_vertex(input int mode);
        return make_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                           rand_coord(mode), rand_coord(mode));
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
    endtask

    // receiver: random stalls, with one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            m_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_frame(m_tdata, m_tuser);

    initial
    begin
        vertex_t a, b, c;
        board = new();
        hold_off_cycles = 0;
        stimulus_done = 0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed faces: plain, flipped, extremes, zero det, zero and collinear edges, small, random
        a = make_vertex(0, 0, 0, 0, 0);
        b = make_vertex(32'h10000, 0, 0, 32'h10000, 0);
        c = make_vertex(0, 32'h10000, 0, 0, 32'h10000);
        send_face(a, b, c);
        send_face(a, c, b);
        send_face(make_vertex(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                              32'h80000000),
                  make_vertex(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                              32'h80000000),
                  make_vertex(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                              32'h7FFFFFFF));
        send_face(make_vertex(1, 2, 3, 5, 5), make_vertex(4, 5, 6, 5, 5),
                  make_vertex(7, 9, 1, 5, 5));
        send_face(make_vertex(1, 1, 1, 0, 0), make_vertex(1, 1, 1, 3, 0),
                  make_vertex(1, 1, 1, 0, 7));
        send_face(make_vertex(0, 0, 0, 0, 0), make_vertex(2, 4, 6, 1, 1),
                  make_vertex(4, 8, 12, 3, 2));
        send_face(make_vertex(-1, -1, -1, -1, -1), make_vertex(0, 0, 0, 0, -1),
                  make_vertex(-1, 0, 0, -1, 0));
        send_face(rand_vertex(0), rand_vertex(0), rand_vertex(0));

        // pause until everything is back, then stall the output for a long while
        drain();
        hold_off_cycles = 2000;
        for (int i = 0; i < 30; i++) send_vertex(rand_vertex($urandom_range(0, 3)));

        for (int i = 0; i < N_RANDOM; i++)
            send_vertex(rand_vertex($urandom_range(0, 9) < 4 ? 0 :
                                    $urandom_range(1, 3)));
        // finish any open face
        while (board.phase != 0) send_vertex(rand_vertex(1));

        drain();
        repeat (SETTLE) @(posedge clk);
        $display("Checked %0d faces (%0d degenerate) from about %0d vertices,",
                 board.frames_seen, board.degenerate_seen, N_RANDOM + 54);
        $display("with random gaps, stalls and one long output hold-off.");
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
